// ----- hw/rtl/fssr_pkg.sv -----
// Package: shared types, constants and the level-to-PWM mapping for the fan regulator.
`timescale 1ns / 1ps
package fssr_pkg;

  localparam int OUT_FANS    = 6;
  localparam int FULL_LEVEL  = 100;
  localparam int PWM_SCALE   = 65536;
  localparam logic [7:0] LEVEL_MAX   = 8'd200;
  localparam logic [7:0] SAVED_RESET = 8'd50;
  localparam logic [15:0] PWM_FULL   = 16'hFFFF;

  // register indexes of the configuration port
  localparam logic [2:0] REG_CLOSED_LOOP    = 3'd0;
  localparam logic [2:0] REG_FAN_COUNT      = 3'd1;
  localparam logic [2:0] REG_DEADBAND       = 3'd2;
  localparam logic [2:0] REG_LEVEL_STEP     = 3'd3;
  localparam logic [2:0] REG_STALL_LIMIT    = 3'd4;
  localparam logic [2:0] REG_MIN_LEVEL      = 3'd5;
  localparam logic [2:0] REG_FALLBACK_LEVEL = 3'd6;
  localparam logic [2:0] REG_SETTLE_PERIODS = 3'd7;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SET  = 1'b1;

  typedef logic [15:0] pwm_tbl_t [128];

  function automatic pwm_tbl_t build_pwm_tbl();
    pwm_tbl_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = (i < FULL_LEVEL) ? 16'((i * PWM_SCALE) / FULL_LEVEL) : PWM_FULL;
    end
    return t;
  endfunction

  // percent (0..127) to duty word, 100 and above is full scale
  localparam pwm_tbl_t PWM_TBL = build_pwm_tbl();

  function automatic logic [15:0] level_to_pwm(logic [7:0] lvl, logic [6:0] min_lvl);
    logic [15:0] w;
    if (lvl < {1'b0, min_lvl}) begin
      w = '0;
    end else if (lvl < 8'(FULL_LEVEL)) begin
      w = PWM_TBL[lvl[6:0]];
    end else begin
      w = PWM_FULL;
    end
    return w;
  endfunction

  typedef struct packed {
    logic [7:0]  deadband;
    logic [5:0]  level_step;
    logic [7:0]  stall_limit;
    logic [6:0]  min_level;
    logic [6:0]  fallback_level;
    logic [15:0] target_speed;
  } fssr_cfg_t;

  typedef struct packed {
    logic        step;        // word accepted this cycle
    logic        is_set;
    logic        closed_loop;
    logic        regulate;    // settling done and target nonzero
    logic        was_off;     // target was zero before this set
    logic        set_nonzero;
    logic [15:0] open_pwm;    // duty word for an open loop set
  } fssr_ctrl_t;

  typedef struct packed {
    logic [OUT_FANS-1:0][15:0] pwm;
    logic [OUT_FANS-1:0]       blocked_mask;
  } fssr_res_t;

endpackage

// ----- hw/rtl/fssr_if.sv -----
// Interfaces: input word channel and result word channel.
`timescale 1ns / 1ps
interface fssr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] set_value;
  logic [15:0] speed_0;
  logic [15:0] speed_1;
  logic [15:0] speed_2;
  logic [15:0] speed_3;
  logic [15:0] speed_4;
  logic [15:0] speed_5;

  modport source (output valid, mode, set_value, speed_0, speed_1, speed_2, speed_3,
                  speed_4, speed_5, input ready);
  modport sink (input valid, mode, set_value, speed_0, speed_1, speed_2, speed_3,
                speed_4, speed_5, output ready);
endinterface

interface fssr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pwm_0;
  logic [15:0] pwm_1;
  logic [15:0] pwm_2;
  logic [15:0] pwm_3;
  logic [15:0] pwm_4;
  logic [15:0] pwm_5;
  logic [5:0]  blocked_mask;

  modport source (output valid, pwm_0, pwm_1, pwm_2, pwm_3, pwm_4, pwm_5, blocked_mask,
                  input ready);
  modport sink (input valid, pwm_0, pwm_1, pwm_2, pwm_3, pwm_4, pwm_5, blocked_mask,
                output ready);
endinterface

// ----- hw/rtl/fssr_lane.sv -----
// Per-fan lane: level, saved level, stall count and duty word of one fan.
`timescale 1ns / 1ps
module fssr_lane
  import fssr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  fssr_ctrl_t  ctrl,
  input  fssr_cfg_t   cfg,
  input  logic        active,
  input  logic        reg_ok,
  input  logic [15:0] speed,
  output logic [15:0] pwm_nxt,
  output logic        blocked_nxt
);

  logic [7:0]  level_r, level_nxt;
  logic [7:0]  saved_r, saved_nxt;
  logic [7:0]  stall_r, stall_nxt;
  logic [15:0] pwm_r;

  logic [16:0] sp_ext, tgt_ext, db_ext;
  logic        faster, slower, blocked_now;
  logic [7:0]  down_lvl, up_lvl, reg_lvl, clr_lvl;
  logic [8:0]  up_sum;

  always_comb begin
    sp_ext   = {1'b0, speed};
    tgt_ext  = {1'b0, cfg.target_speed};
    db_ext   = {9'd0, cfg.deadband};
    faster   = sp_ext > (tgt_ext + db_ext);
    slower   = (sp_ext + db_ext) < tgt_ext;
    down_lvl = (level_r > {2'b0, cfg.level_step}) ? (level_r - {2'b0, cfg.level_step}) : 8'd0;
    up_sum   = {1'b0, level_r} + {3'b0, cfg.level_step};
    up_lvl   = (up_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : up_sum[7:0];
    reg_lvl  = faster ? down_lvl : (slower ? up_lvl : level_r);
    blocked_now = stall_r >= cfg.stall_limit;
    clr_lvl  = ctrl.was_off ? 8'd0 : level_r;

    level_nxt = level_r;
    saved_nxt = saved_r;
    stall_nxt = stall_r;
    pwm_nxt   = pwm_r;
    if (ctrl.step) begin
      if (ctrl.is_set) begin
        if (ctrl.closed_loop) begin
          if (ctrl.was_off) begin
            stall_nxt = 8'd0;
          end
          if (ctrl.set_nonzero && ctrl.was_off) begin
            level_nxt = saved_r;
          end else begin
            level_nxt = clr_lvl;
            saved_nxt = clr_lvl;
          end
          if (active) begin
            pwm_nxt = level_to_pwm(level_nxt, cfg.min_level);
          end
        end else begin
          pwm_nxt = ctrl.open_pwm;
        end
      end else if (ctrl.closed_loop) begin
        if (ctrl.regulate && active && reg_ok) begin
          if (blocked_now) begin
            level_nxt = {1'b0, cfg.fallback_level};
          end else begin
            level_nxt = reg_lvl;
            if (reg_lvl >= 8'(FULL_LEVEL) && stall_r != 8'hFF) begin
              stall_nxt = stall_r + 8'd1;
            end
          end
        end
        if (active) begin
          pwm_nxt = level_to_pwm(level_nxt, cfg.min_level);
        end
      end
    end
    blocked_nxt = stall_nxt >= cfg.stall_limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      saved_r <= SAVED_RESET;
      stall_r <= '0;
      pwm_r   <= '0;
    end else begin
      level_r <= level_nxt;
      saved_r <= saved_nxt;
      stall_r <= stall_nxt;
      pwm_r   <= pwm_nxt;
    end
  end

endmodule

// ----- hw/rtl/fssr_obuf.sv -----
// Result buffer: output register plus skid stage.
`timescale 1ns / 1ps
module fssr_obuf
  import fssr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fssr_res_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output fssr_res_t out_data
);

  logic      out_valid_r;
  logic      skid_valid_r;
  fssr_res_t out_data_r;
  fssr_res_t skid_data_r;
  logic      slot_free;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : in_data;
    end else if (in_valid && in_ready) begin
      skid_data_r <= in_data;
    end
  end

endmodule

// ----- hw/rtl/fan_speed_step_regulator_top.sv -----
// Top level: step speed regulator for up to MAX_FANS fans.
`timescale 1ns / 1ps
// Step regulator for a bank of fans. Each input word is either a set word
// (mode 1, new target speed, or a duty percentage in open loop) or a tick
// word (mode 0, one control period with the measured fan speeds). Every
// accepted word produces exactly one result word carrying all six PWM duty
// words and the blocked-fan mask, reflecting the state after that word.
// Throughput: one word per clock unless the output buffer is full; results are
// registered onto out_word. Each fan has its own lane (level, saved level, stall
// counter, duty word) and all lanes update in the accept cycle; the lane
// path (speed compare, level step, duty lookup) sets the clock. A two-deep
// output buffer (register plus skid) keeps the input open while one result
// waits on the output side. Configuration goes through cfg_we/cfg_index/
// cfg_data and must only be written while no word is in flight. After
// reset the block is ready at once; no clearing pass is needed.
module fan_speed_step_regulator_top
  import fssr_pkg::*;
#(
  parameter int MAX_FANS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  fssr_in_if.sink     in_word,
  fssr_out_if.source  out_word,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // configuration registers
  logic        closed_loop_r;
  logic [2:0]  fan_count_r;
  logic [7:0]  deadband_r;
  logic [5:0]  level_step_r;
  logic [7:0]  stall_limit_r;
  logic [6:0]  min_level_r;
  logic [6:0]  fallback_level_r;
  logic [7:0]  settle_periods_r;

  // global regulator state
  logic [15:0] target_r, target_nxt;
  logic [7:0]  settle_r, settle_nxt;

  logic        accept;
  logic        buf_ready;
  fssr_ctrl_t  ctrl;
  fssr_cfg_t   cfg;
  fssr_res_t   res_nxt;
  fssr_res_t   res_out;

  logic [15:0] speed_in [OUT_FANS];
  logic [15:0] lane_pwm [MAX_FANS];
  logic        lane_blk [MAX_FANS];

  assign in_word.ready = buf_ready;
  assign accept = in_word.valid && buf_ready;

  assign speed_in[0] = in_word.speed_0;
  assign speed_in[1] = in_word.speed_1;
  assign speed_in[2] = in_word.speed_2;
  assign speed_in[3] = in_word.speed_3;
  assign speed_in[4] = in_word.speed_4;
  assign speed_in[5] = in_word.speed_5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_loop_r    <= 1'b1;
      fan_count_r      <= 3'd4;
      deadband_r       <= 8'd2;
      level_step_r     <= 6'd5;
      stall_limit_r    <= 8'd50;
      min_level_r      <= 7'd30;
      fallback_level_r <= 7'd40;
      settle_periods_r <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLOSED_LOOP:    closed_loop_r    <= cfg_data[0];
        REG_FAN_COUNT:      fan_count_r      <= cfg_data[2:0];
        REG_DEADBAND:       deadband_r       <= cfg_data;
        REG_LEVEL_STEP:     level_step_r     <= cfg_data[5:0];
        REG_STALL_LIMIT:    stall_limit_r    <= cfg_data;
        REG_MIN_LEVEL:      min_level_r      <= cfg_data[6:0];
        REG_FALLBACK_LEVEL: fallback_level_r <= cfg_data[6:0];
        REG_SETTLE_PERIODS: settle_periods_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // control word broadcast to all lanes
  always_comb begin
    ctrl.step        = accept;
    ctrl.is_set      = (in_word.mode == MODE_SET);
    ctrl.closed_loop = closed_loop_r;
    ctrl.regulate    = (settle_r == 8'd0) && (target_r != 16'd0);
    ctrl.was_off     = (target_r == 16'd0);
    ctrl.set_nonzero = (in_word.set_value != 16'd0);
    // open loop: percentage through the same duty table
    ctrl.open_pwm    = (in_word.set_value < 16'(FULL_LEVEL)) ?
                       PWM_TBL[in_word.set_value[6:0]] : PWM_FULL;

    cfg.deadband       = deadband_r;
    cfg.level_step     = level_step_r;
    cfg.stall_limit    = stall_limit_r;
    cfg.min_level      = min_level_r;
    cfg.fallback_level = fallback_level_r;
    cfg.target_speed   = target_r;
  end

  // target and settle countdown
  always_comb begin
    target_nxt = target_r;
    settle_nxt = settle_r;
    if (accept && closed_loop_r) begin
      if (in_word.mode == MODE_SET) begin
        target_nxt = in_word.set_value;
        settle_nxt = settle_periods_r;
      end else if (settle_r != 8'd0) begin
        settle_nxt = settle_r - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      settle_r <= '0;
    end else begin
      target_r <= target_nxt;
      settle_r <= settle_nxt;
    end
  end

  // one lane per fan; lanes past the six output fields are refreshed but
  // never regulated
  for (genvar g = 0; g < MAX_FANS; g++) begin : g_lane
    logic [15:0] spd;
    if (g < OUT_FANS) begin : g_spd
      assign spd = speed_in[g];
    end else begin : g_nospd
      assign spd = '0;
    end

    fssr_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .cfg         (cfg),
      .active      (32'(fan_count_r) > g),
      .reg_ok      (g < OUT_FANS),
      .speed       (spd),
      .pwm_nxt     (lane_pwm[g]),
      .blocked_nxt (lane_blk[g])
    );
  end

  // merge: gather lane results into one result word
  for (genvar j = 0; j < OUT_FANS; j++) begin : g_merge
    if (j < MAX_FANS) begin : g_used
      assign res_nxt.pwm[j]          = lane_pwm[j];
      assign res_nxt.blocked_mask[j] = lane_blk[j];
    end else begin : g_empty
      assign res_nxt.pwm[j]          = '0;
      assign res_nxt.blocked_mask[j] = 1'b0;
    end
  end

  fssr_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_ready  (buf_ready),
    .in_data   (res_nxt),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .out_data  (res_out)
  );

  assign out_word.pwm_0        = res_out.pwm[0];
  assign out_word.pwm_1        = res_out.pwm[1];
  assign out_word.pwm_2        = res_out.pwm[2];
  assign out_word.pwm_3        = res_out.pwm[3];
  assign out_word.pwm_4        = res_out.pwm[4];
  assign out_word.pwm_5        = res_out.pwm[5];
  assign out_word.blocked_mask = res_out.blocked_mask;

endmodule
